@@ hw/rtl/hav_pkg.sv @@
// package for the haversine distance pipeline: constants, atan table and stage types
package hav_pkg;

  localparam int CoordFracBits = 23;
  localparam int DistFracBits  = 8;
  localparam int CordicStages  = 32;
  localparam int RootStages    = 31;

  localparam int LatW  = 31;
  localparam int LonW  = 32;
  localparam int DistW = 34;
  localparam int RadW  = 24;

  // datapath width for cordic and root work, signed
  localparam int DW = 64;

  localparam logic [63:0] Pi60       = 64'h3243F6A8885A308D;
  localparam logic [63:0] HalfDegQ38 = ((Pi60 / 64'd360) + (64'd1 << 21)) >> 22;
  localparam logic signed [DW-1:0] OneQ30    = 64'sd1 <<< 30;
  localparam logic signed [DW-1:0] HalfPiQ30 = DW'((Pi60 + (64'd1 << 30)) >> 31);
  localparam logic signed [DW-1:0] GainQ30   = 64'sh26DD3B6A;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic [RadW-1:0] RadiusReset = 24'd6371000;

  localparam logic signed [LatW-1:0] LatLim = LatW'(64'd90 << CoordFracBits);
  localparam logic [33:0] Full180 = 34'(64'd180 << CoordFracBits);
  localparam logic [33:0] Full360 = 34'(64'd360 << CoordFracBits);

  // atan(2^-i) in q30, series evaluated at elaboration
  function automatic logic signed [DW-1:0] atan_q30(input int i);
    logic [63:0] s;
    logic [63:0] t;
    int e;
    s = 64'd0;
    if (i == 0) begin
      s = Pi60 >> 2;
    end else begin
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          t = (64'd1 << e) / 64'(2 * k + 1);
          if (k % 2 == 1) s = s - t;
          else s = s + t;
        end
      end
    end
    return DW'((s + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic signed [DW-1:0] clamp01(input logic signed [DW-1:0] v);
    if (v < 0) return '0;
    if (v > OneQ30) return OneQ30;
    return v;
  endfunction

  // half angle of an unsigned coordinate quantity, q30 radians
  function automatic logic signed [DW-1:0] half_angle(input logic [33:0] u);
    logic [63:0] p;
    p = 64'(u) * HalfDegQ38 + (64'd1 << (7 + CoordFracBits));
    return DW'(p >> (8 + CoordFracBits));
  endfunction

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } cordic_t;

endpackage

@@ hw/rtl/haversine_distance.sv @@
// top level of the haversine great-circle distance pipeline
// One point pair is taken every clock cycle (busy stays low). Its distance
// appears on out_distance once the beat has passed the chain of register
// stages, and out_valid marks it for a single cycle. The first stage loads
// on the accepting edge. The chain holds the angle prep stages, 32
// sine/cosine cordic stages, 3 multiply stages, 31 root stages, 32 atan2
// cordic stages, the scaling and saturation stages and the output register.
// The receiver cannot stall, so nothing holds the pipeline
// and every beat taken in comes out. cfg_sphere_radius_m sets the radius in
// whole metres; write it only while no beat is in flight.
module haversine_distance (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [hav_pkg::LatW-1:0] in_lat_a,
  input  logic signed [hav_pkg::LonW-1:0] in_lon_a,
  input  logic signed [hav_pkg::LatW-1:0] in_lat_b,
  input  logic signed [hav_pkg::LonW-1:0] in_lon_b,
  input  logic cfg_we,
  input  logic [hav_pkg::RadW-1:0] cfg_sphere_radius_m,
  output logic out_valid,
  output logic [hav_pkg::DistW-1:0] out_distance
);
  import hav_pkg::*;

  localparam int Lat = 3 + CordicStages + 3 + RootStages + CordicStages + 2;

  logic [RadW-1:0] radius_r;
  logic [Lat-1:0] vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RadiusReset;
    else if (cfg_we) radius_r <= cfg_sphere_radius_m;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Lat-2:0], start};
  end

  // prep stage 1: clamp latitudes, differences
  logic [33:0] ua_r, ub_r, dp_r, dl_r;
  logic signed [LatW-1:0] la_c, lb_c;
  logic signed [33:0] dp_s, dl_s;
  always_comb begin
    la_c = (in_lat_a > LatLim) ? LatLim : ((in_lat_a < -LatLim) ? -LatLim : in_lat_a);
    lb_c = (in_lat_b > LatLim) ? LatLim : ((in_lat_b < -LatLim) ? -LatLim : in_lat_b);
    dp_s = 34'(lb_c) - 34'(la_c);
    dl_s = 34'(in_lon_b) - 34'(in_lon_a);
  end
  always_ff @(posedge clk) begin
    ua_r <= (la_c < 0) ? 34'(-34'(la_c)) << 1 : 34'(la_c) << 1;
    ub_r <= (lb_c < 0) ? 34'(-34'(lb_c)) << 1 : 34'(lb_c) << 1;
    dp_r <= (dp_s < 0) ? 34'(-dp_s) : 34'(dp_s);
    dl_r <= (dl_s < 0) ? 34'(-dl_s) : 34'(dl_s);
  end

  // prep stage 2: fold longitude into [0, 180] deg (|dl| < 3*360 deg)
  logic [33:0] m_c, m_r, ua2_r, ub2_r, dp2_r;
  always_comb begin
    m_c = dl_r;
    if (m_c >= Full360) m_c = m_c - Full360;
    if (m_c >= Full360) m_c = m_c - Full360;
    if (m_c > Full180) m_c = Full360 - m_c;
  end
  always_ff @(posedge clk) begin
    m_r   <= m_c;
    ua2_r <= ua_r;
    ub2_r <= ub_r;
    dp2_r <= dp_r;
  end

  // prep stage 3: half angles
  logic signed [DW-1:0] ha_r, hb_r, hp_r, hl_r;
  always_ff @(posedge clk) begin
    ha_r <= half_angle(ua2_r);
    hb_r <= half_angle(ub2_r);
    hp_r <= half_angle(dp2_r);
    hl_r <= half_angle(m_r);
  end

  logic signed [DW-1:0] c1, c2, sp, sl, unused_s0, unused_s1, unused_c0, unused_c1;
  hav_rotate u_rot_a (.clk, .en(1'b1), .angle(ha_r), .cos_q(c1), .sin_q(unused_s0));
  hav_rotate u_rot_b (.clk, .en(1'b1), .angle(hb_r), .cos_q(c2), .sin_q(unused_s1));
  hav_rotate u_rot_p (.clk, .en(1'b1), .angle(hp_r), .cos_q(unused_c0), .sin_q(sp));
  hav_rotate u_rot_l (.clk, .en(1'b1), .angle(hl_r), .cos_q(unused_c1), .sin_q(sl));

  // three multiply stages, values are within [0, 1] q30 so 31 bits carry them
  logic signed [DW-1:0] spp_r, cc_r, sll_r, spp2_r, prod_r, a_r;
  logic [30:0] c1_u, c2_u, sp_u, sl_u, cc_u, sll_u;
  assign c1_u  = c1[30:0];
  assign c2_u  = c2[30:0];
  assign sp_u  = sp[30:0];
  assign sl_u  = sl[30:0];
  assign cc_u  = cc_r[30:0];
  assign sll_u = sll_r[30:0];
  always_ff @(posedge clk) begin
    spp_r  <= DW'((62'(sp_u) * 62'(sp_u) + (62'd1 << 29)) >> 30);
    cc_r   <= DW'((62'(c1_u) * 62'(c2_u) + (62'd1 << 29)) >> 30);
    sll_r  <= DW'((62'(sl_u) * 62'(sl_u) + (62'd1 << 29)) >> 30);
    spp2_r <= spp_r;
    prod_r <= DW'((62'(cc_u) * 62'(sll_u) + (62'd1 << 29)) >> 30);
    a_r    <= clamp01(spp2_r + prod_r);
  end

  logic signed [DW-1:0] ry, rx, t_raw;
  hav_root u_root_y (.clk, .en(1'b1), .v(a_r), .root(ry));
  hav_root u_root_x (.clk, .en(1'b1), .v(OneQ30 - a_r), .root(rx));

  hav_vector u_vec (.clk, .en(1'b1), .x_in(rx), .y_in(ry), .angle(t_raw));

  // scale by radius, round and saturate
  logic [30:0] t_r;
  logic [55:0] p_r;
  logic [55:0] d_c;
  always_ff @(posedge clk) begin
    t_r <= (t_raw < 0) ? '0 : ((t_raw > HalfPiQ30) ? 31'(HalfPiQ30) : 31'(t_raw));
    p_r <= 56'(radius_r) * 56'(t_r);
  end
  assign d_c = (p_r + (56'd1 << (28 - DistFracBits))) >> (29 - DistFracBits);

  always_ff @(posedge clk) begin
    out_distance <= (d_c > 56'(DistMax)) ? DistMax : DistW'(d_c);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vld_r[Lat-1];
  end

  property p_latency;
    @(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##(Lat+1) out_valid;
  endproperty
  a_latency: assert property (p_latency) else $error("beat lost in pipeline");

  property p_no_phantom;
    @(posedge clk) disable iff (!rst_n) out_valid |-> $past(vld_r[Lat-1]);
  endproperty
  a_no_phantom: assert property (p_no_phantom) else $error("result without beat");

  property p_sat;
    @(posedge clk) disable iff (!rst_n) out_valid |-> (out_distance <= DistMax);
  endproperty
  a_sat: assert property (p_sat) else $error("distance out of range");
endmodule

@@ hw/rtl/hav_rotate.sv @@
// pipelined rotation-mode cordic: cosine and sine of a q30 angle
module hav_rotate (
  input  logic clk,
  input  logic en,
  input  logic signed [hav_pkg::DW-1:0] angle,
  output logic signed [hav_pkg::DW-1:0] cos_q,
  output logic signed [hav_pkg::DW-1:0] sin_q
);
  import hav_pkg::*;

  cordic_t st_r [CordicStages+1];

  always_comb begin
    st_r[0].x = GainQ30;
    st_r[0].y = '0;
    st_r[0].z = angle;
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    localparam logic signed [DW-1:0] Atan = atan_q30(i);
    cordic_t nxt;
    cordic_t q_r;
    always_comb begin
      if (st_r[i].z >= 0) begin
        nxt.x = st_r[i].x - (st_r[i].y >>> i);
        nxt.y = st_r[i].y + (st_r[i].x >>> i);
        nxt.z = st_r[i].z - Atan;
      end else begin
        nxt.x = st_r[i].x + (st_r[i].y >>> i);
        nxt.y = st_r[i].y - (st_r[i].x >>> i);
        nxt.z = st_r[i].z + Atan;
      end
    end
    always_ff @(posedge clk) begin
      if (en) q_r <= nxt;
    end
    assign st_r[i+1] = q_r;
  end

  assign cos_q = clamp01(st_r[CordicStages].x);
  assign sin_q = clamp01(st_r[CordicStages].y);
endmodule

@@ hw/rtl/hav_vector.sv @@
// pipelined vectoring-mode cordic: angle of (x, y)
module hav_vector (
  input  logic clk,
  input  logic en,
  input  logic signed [hav_pkg::DW-1:0] x_in,
  input  logic signed [hav_pkg::DW-1:0] y_in,
  output logic signed [hav_pkg::DW-1:0] angle
);
  import hav_pkg::*;

  cordic_t st_r [CordicStages+1];

  always_comb begin
    st_r[0].x = x_in;
    st_r[0].y = y_in;
    st_r[0].z = '0;
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_stage
    localparam logic signed [DW-1:0] Atan = atan_q30(i);
    cordic_t nxt;
    cordic_t q_r;
    always_comb begin
      if (st_r[i].y >= 0) begin
        nxt.x = st_r[i].x + (st_r[i].y >>> i);
        nxt.y = st_r[i].y - (st_r[i].x >>> i);
        nxt.z = st_r[i].z + Atan;
      end else begin
        nxt.x = st_r[i].x - (st_r[i].y >>> i);
        nxt.y = st_r[i].y + (st_r[i].x >>> i);
        nxt.z = st_r[i].z - Atan;
      end
    end
    always_ff @(posedge clk) begin
      if (en) q_r <= nxt;
    end
    assign st_r[i+1] = q_r;
  end

  assign angle = st_r[CordicStages].z;
endmodule

@@ hw/rtl/hav_root.sv @@
// pipelined restoring square root of a q30 value, one result bit per stage
module hav_root (
  input  logic clk,
  input  logic en,
  input  logic signed [hav_pkg::DW-1:0] v,
  output logic signed [hav_pkg::DW-1:0] root
);
  import hav_pkg::*;

  logic [63:0] n_r [RootStages+1];
  logic [63:0] r_r [RootStages+1];

  assign n_r[0] = 64'(v) << 30;
  assign r_r[0] = '0;

  for (genvar s = 0; s < RootStages; s++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (60 - 2 * s);
    logic [63:0] n_q, r_q, n_nxt, r_nxt;
    always_comb begin
      if (n_r[s] >= r_r[s] + Bit) begin
        n_nxt = n_r[s] - (r_r[s] + Bit);
        r_nxt = (r_r[s] >> 1) + Bit;
      end else begin
        n_nxt = n_r[s];
        r_nxt = r_r[s] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_q <= n_nxt;
        r_q <= r_nxt;
      end
    end
    assign n_r[s+1] = n_q;
    assign r_r[s+1] = r_q;
  end

  assign root = DW'(r_r[RootStages]);
endmodule

@@ verif/tb.sv @@
// testbench for the haversine distance pipeline, with its own distance predictor
`timescale 1ns / 1ps

class dist_board;
  longint unsigned radius_m;
  longint atan_q30[hav_pkg::CordicStages];
  longint unsigned dist_due[$];
  int mismatches;
  int beats_in;
  int beats_out;

  function new();
    longint unsigned s;
    longint unsigned t;
    int e;
    radius_m = hav_pkg::RadiusReset;
    mismatches = 0;
    beats_in = 0;
    beats_out = 0;
    atan_q30[0] = longint'(((hav_pkg::Pi60 >> 2) + (64'd1 << 29)) >> 30);
    for (int i = 1; i < hav_pkg::CordicStages; i++) begin
      s = 0;
      for (int k = 0; k < 64; k++) begin
        e = 60 - i * (2 * k + 1);
        if (e >= 0) begin
          t = (64'd1 << e) / longint'(2 * k + 1);
          if (k % 2 == 1) s = s - t;
          else s = s + t;
        end
      end
      atan_q30[i] = longint'((s + (64'd1 << 29)) >> 30);
    end
  endfunction

  function longint unit_clip(longint v);
    if (v < 0) return 0;
    if (v > hav_pkg::OneQ30) return hav_pkg::OneQ30;
    return v;
  endfunction

  // q30 half angle in radians of a coordinate magnitude
  function longint half_rad(longint unsigned u);
    return longint'((u * hav_pkg::HalfDegQ38 + (64'd1 << (7 + hav_pkg::CoordFracBits)))
                    >> (8 + hav_pkg::CoordFracBits));
  endfunction

  function void sin_cos(longint z, output longint c, output longint s);
    longint x, y, xn;
    x = hav_pkg::GainQ30;
    y = 0;
    for (int i = 0; i < hav_pkg::CordicStages; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_q30[i];
      end else begin
        xn = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_q30[i];
      end
      x = xn;
    end
    c = unit_clip(x);
    s = unit_clip(y);
  endfunction

  function longint angle_of(longint x, longint y);
    longint z, xn;
    z = 0;
    for (int i = 0; i < hav_pkg::CordicStages; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_q30[i];
      end else begin
        xn = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_q30[i];
      end
      x = xn;
    end
    return z;
  endfunction

  function longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function longint qroot(longint v);
    longint unsigned n, r, b;
    n = longint'(v) << 30;
    r = 0;
    for (int s = 0; s < hav_pkg::RootStages; s++) begin
      b = 64'd1 << (60 - 2 * s);
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return longint'(r);
  endfunction

  function void note(longint la, longint oa, longint lb, longint ob);
    longint lim, dp, dl, c1, c2, junk, sp, sl, hav, ang;
    longint unsigned f180, f360, m, p, d;
    lim = longint'(90) <<< hav_pkg::CoordFracBits;
    f180 = 64'd180 << hav_pkg::CoordFracBits;
    f360 = f180 * 2;
    if (la > lim) la = lim;
    if (la < -lim) la = -lim;
    if (lb > lim) lb = lim;
    if (lb < -lim) lb = -lim;
    dp = lb - la;
    if (dp < 0) dp = -dp;
    dl = ob - oa;
    if (dl < 0) dl = -dl;
    m = longint'(dl) % f360;
    if (m > f180) m = f360 - m;
    sin_cos(half_rad((la < 0 ? -la : la) * 2), c1, junk);
    sin_cos(half_rad((lb < 0 ? -lb : lb) * 2), c2, junk);
    sin_cos(half_rad(dp), junk, sp);
    sin_cos(half_rad(m), junk, sl);
    hav = unit_clip(qmul(sp, sp) + qmul(qmul(c1, c2), qmul(sl, sl)));
    ang = angle_of(qroot(hav_pkg::OneQ30 - hav), qroot(hav));
    if (ang < 0) ang = 0;
    if (ang > hav_pkg::HalfPiQ30) ang = hav_pkg::HalfPiQ30;
    p = radius_m * longint'(ang);
    d = (p + (64'd1 << (28 - hav_pkg::DistFracBits))) >> (29 - hav_pkg::DistFracBits);
    if (d > hav_pkg::DistMax) d = hav_pkg::DistMax;
    dist_due.push_back(d);
    beats_in++;
  endfunction

  function void check(longint unsigned got);
    longint unsigned want;
    beats_out++;
    if (dist_due.size() == 0) begin
      $display("%0t: distance %0d with no beat outstanding", $time, got);
      mismatches++;
      return;
    end
    want = dist_due.pop_front();
    if (want != got) begin
      $display("%0t: distance expected %0d actual %0d", $time, want, got);
      mismatches++;
    end
  endfunction
endclass

module tb;
  import hav_pkg::*;

  localparam longint LatSpan = 754974720;
  localparam longint LonSpan = 1509949440;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [LatW-1:0] in_lat_a = '0;
  logic signed [LonW-1:0] in_lon_a = '0;
  logic signed [LatW-1:0] in_lat_b = '0;
  logic signed [LonW-1:0] in_lon_b = '0;
  logic cfg_we = 1'b0;
  logic [RadW-1:0] cfg_sphere_radius_m = RadiusReset;
  logic out_valid;
  logic [DistW-1:0] out_distance;

  dist_board board = new();
  int radii_seen = 0;

  always #5 clk = ~clk;

  haversine_distance dut (.*);

  // every beat taken in is predicted, every output beat is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note(in_lat_a, in_lon_a, in_lat_b, in_lon_b);
      if (out_valid) board.check(out_distance);
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  task automatic send_pair(longint la, longint oa, longint lb, longint ob);
    in_lat_a = LatW'(la);
    in_lon_a = LonW'(oa);
    in_lat_b = LatW'(lb);
    in_lon_b = LonW'(ob);
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // drain the pipe completely, then a margin for the latency
  task automatic drain();
    start = 1'b0;
    while (board.dist_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_radius(longint unsigned r);
    drain();
    cfg_we = 1'b1;
    cfg_sphere_radius_m = RadW'(r);
    board.radius_m = r & 64'hFFFFFF;
    @(negedge clk);
    cfg_we = 1'b0;
    radii_seen++;
  endtask

  function automatic longint rand_lat();
    if ($urandom_range(0, 3) == 0) return longint'($signed(LatW'($urandom)));
    return longint'($urandom_range(0, 2 * LatSpan)) - LatSpan;
  endfunction

  function automatic longint rand_lon();
    if ($urandom_range(0, 3) == 0) return longint'($signed($urandom));
    return longint'($urandom_range(0, 2 * LonSpan)) - LonSpan;
  endfunction

  task automatic random_run(int n, bit quiet);
    longint la, oa;
    for (int i = 0; i < n; i++) begin
      if (!quiet && $urandom_range(0, 5) == 0) pause($urandom_range(1, 11));
      la = rand_lat();
      oa = rand_lon();
      case ($urandom_range(0, 7))
        // near neighbours and near antipodes stress the small and large angle ends
        0: send_pair(la, oa, la + $urandom_range(0, 4000) - 2000,
                     oa + $urandom_range(0, 4000) - 2000);
        1: send_pair(la, oa, -la, oa + (longint'(180) <<< CoordFracBits));
        default: send_pair(la, oa, rand_lat(), rand_lon());
      endcase
    end
  endtask

  initial begin
    longint deg;
    deg = longint'(1) <<< CoordFracBits;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed beats at the reset radius
    send_pair(0, 0, 0, 0);
    send_pair(LatSpan, LonSpan, LatSpan, LonSpan);
    send_pair(0, 0, 0, 180 * deg);
    send_pair(0, -90 * deg, 0, 90 * deg);
    send_pair(90 * deg, 0, -90 * deg, 0);
    send_pair(-90 * deg, 17 * deg, 90 * deg, -100 * deg);
    send_pair(2 ** 30 - 1, 0, -(2 ** 30), 0);
    send_pair(-(2 ** 30), 5, 2 ** 30 - 1, -5);
    send_pair(0, -(longint'(2) ** 31), 0, longint'(2) ** 31 - 1);
    send_pair(0, longint'(2) ** 31 - 1, 0, -(longint'(2) ** 31));
    send_pair(10 * deg, 0, 10 * deg, 400 * deg);
    send_pair(10 * deg, 0, 10 * deg, 360 * deg);
    send_pair(-30 * deg, 179 * deg, -30 * deg, -179 * deg);
    send_pair(45 * deg, 1, 45 * deg, 0);
    send_pair(-1, -1, 1, 1);
    send_pair(51 * deg, -2, 40 * deg, -74 * deg);
    send_pair(-LatSpan, -LonSpan, LatSpan, LonSpan);
    send_pair(LatW'(31'h2AAAAAAA), 32'h55555555, LatW'(31'h55555555), 32'hAAAAAAAA);
    pause(3);
    random_run(300, 1'b0);

    set_radius(1);
    send_pair(0, 0, 0, 180 * deg);
    send_pair(90 * deg, 0, -90 * deg, 0);
    random_run(250, 1'b0);

    set_radius(24'hFFFFFF);
    send_pair(0, 0, 0, 180 * deg);
    send_pair(0, 0, 0, 1);
    random_run(250, 1'b0);

    set_radius($urandom_range(1, 24'hFFFFFF));
    random_run(150, 1'b0);
    // hold off until the pipe is empty, then resume
    drain();
    random_run(150, 1'b0);

    set_radius(RadiusReset);
    random_run(200, 1'b0);
    // back-to-back tail with no gaps
    random_run(200, 1'b1);

    start = 1'b0;
    while (board.dist_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("covered %0d point pairs, %0d distances checked, %0d radius settings",
             board.beats_in, board.beats_out, radii_seen);
    if (board.mismatches == 0 && board.dist_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
